// File: src/ipv4cp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4cp_pkg
// Token types and character constants shared by the IPv4 CIDR text parser.
// ----------------------------------------------------------------------------
package ipv4cp_pkg;

	typedef enum logic [1:0] {
		TK_DIGIT = 2'd0,
		TK_DOT   = 2'd1,
		TK_SLASH = 2'd2,
		TK_OTHER = 2'd3
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [3:0] digit;
		logic       last;
	} token_t;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	localparam logic [8:0] OCTET_MAX  = 9'd255;
	localparam logic [8:0] OCTET_SAT  = 9'd256;
	localparam logic [5:0] PREFIX_MAX = 6'd32;
	localparam logic [5:0] PREFIX_SAT = 6'd33;

	localparam logic [2:0] FIELD_LAST_OCTET = 3'd3;
	localparam logic [2:0] FIELD_PREFIX     = 3'd4;

	localparam logic [31:0] MASK_ALL = 32'hFFFF_FFFF;

endpackage

// File: src/ipv4_cidr_text_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_cidr_text_parser_core
// Parses dotted-quad IPv4 text with an optional /prefix, one byte a word.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_stall  | text_byte, end_of_text
//   out     | out_valid / out_stall| accepted, network_address, net_mask,
//           |                      | prefix_length
//
// One input word per cycle sustained while in_stall is low; each string's
// result passes the classify register, the queue and the result register.
// Reset clears the token queue and the parser state; no result is pending
// after reset. A stalled output holds the result; words ahead of the next
// final word drain; then QUEUE_DEPTH + 1 words wait before in_stall rises.
// ----------------------------------------------------------------------------
module ipv4_cidr_text_parser_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        accepted,
	output logic [31:0] network_address,
	output logic [31:0] net_mask,
	output logic [5:0]  prefix_length,
	output logic        out_valid,
	input  logic        out_stall
);

	logic               push_ready;
	logic               tok_valid_s1;
	ipv4cp_pkg::token_t tok_s1;
	logic               q_valid;
	ipv4cp_pkg::token_t q_tok;
	logic               q_pop;

	ipv4cp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.push_ready   (push_ready),
		.tok_valid_s1 (tok_valid_s1),
		.tok_s1       (tok_s1)
	);

	ipv4cp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (tok_valid_s1),
		.push_tok   (tok_s1),
		.push_ready (push_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_tok    (q_tok)
	);

	ipv4cp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.tok_valid       (q_valid),
		.tok             (q_tok),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.network_address (network_address),
		.net_mask        (net_mask),
		.prefix_length   (prefix_length)
	);

endmodule

// File: src/ipv4cp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4cp_front
// Accepts text words and registers them as classified tokens.
// ----------------------------------------------------------------------------
module ipv4cp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          text_byte,
	input  logic                end_of_text,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                push_ready,
	output logic                tok_valid_s1,
	output ipv4cp_pkg::token_t  tok_s1
);

	logic               accept;
	ipv4cp_pkg::token_t tok_d;

	assign in_stall = tok_valid_s1 && !push_ready;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		tok_d.last  = end_of_text;
		tok_d.digit = 4'(text_byte - ipv4cp_pkg::CHAR_ZERO);
		if (text_byte inside {[ipv4cp_pkg::CHAR_ZERO:ipv4cp_pkg::CHAR_NINE]}) begin
			tok_d.kind = ipv4cp_pkg::TK_DIGIT;
		end else if (text_byte == ipv4cp_pkg::CHAR_DOT) begin
			tok_d.kind = ipv4cp_pkg::TK_DOT;
		end else if (text_byte == ipv4cp_pkg::CHAR_SLASH) begin
			tok_d.kind = ipv4cp_pkg::TK_SLASH;
		end else begin
			tok_d.kind = ipv4cp_pkg::TK_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
		end else if (accept) begin
			tok_valid_s1 <= 1'b1;
		end else if (push_ready) begin
			tok_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s1 <= tok_d;
		end
	end

endmodule

// File: src/ipv4cp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4cp_fifo
// Short token queue between the front and the back.
// ----------------------------------------------------------------------------
module ipv4cp_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ipv4cp_pkg::token_t push_tok,
	output logic               push_ready,
	input  logic               pop,
	output logic               pop_valid,
	output ipv4cp_pkg::token_t pop_tok
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	ipv4cp_pkg::token_t mem_q [DEPTH];
	logic [AW-1:0]      wr_ptr_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_tok    = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

// File: src/ipv4cp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4cp_back
// Runs the address/prefix accumulators and registers one result per string.
// ----------------------------------------------------------------------------
module ipv4cp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	input  ipv4cp_pkg::token_t tok,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               accepted,
	output logic [31:0]        network_address,
	output logic [31:0]        net_mask,
	output logic [5:0]         prefix_length
);

	logic [2:0]  field_q;
	logic [8:0]  octet_q;
	logic [31:0] addr_q;
	logic [5:0]  prefix_q;
	logic        reject_q;

	logic [2:0]  field_d;
	logic [8:0]  octet_d;
	logic [31:0] addr_d;
	logic [5:0]  prefix_d;
	logic        reject_d;
	logic [11:0] oct_acc;
	logic [8:0]  pre_acc;

	logic        fin_rej;
	logic [31:0] fin_addr;
	logic [5:0]  fin_prefix;
	logic [31:0] fin_mask;

	assign pop = tok_valid && (!tok.last || !out_valid || !out_stall);

	always_comb begin
		field_d  = field_q;
		octet_d  = octet_q;
		addr_d   = addr_q;
		prefix_d = prefix_q;
		reject_d = reject_q;
		oct_acc  = ({3'b0, octet_q} << 3) + ({3'b0, octet_q} << 1) + {8'b0, tok.digit};
		pre_acc  = ({3'b0, prefix_q} << 3) + ({3'b0, prefix_q} << 1) + {5'b0, tok.digit};
		if (!reject_q) begin
			case (tok.kind)
				ipv4cp_pkg::TK_DIGIT: begin
					if (field_q < ipv4cp_pkg::FIELD_PREFIX) begin
						octet_d = (oct_acc > {3'b0, ipv4cp_pkg::OCTET_SAT}) ?
							ipv4cp_pkg::OCTET_SAT : oct_acc[8:0];
					end else begin
						prefix_d = (pre_acc > {3'b0, ipv4cp_pkg::PREFIX_SAT}) ?
							ipv4cp_pkg::PREFIX_SAT : pre_acc[5:0];
					end
				end
				ipv4cp_pkg::TK_DOT: begin
					if (field_q < ipv4cp_pkg::FIELD_LAST_OCTET) begin
						if (octet_q > ipv4cp_pkg::OCTET_MAX) begin
							reject_d = 1'b1;
						end
						addr_d  = {addr_q[23:0], octet_q[7:0]};
						octet_d = '0;
						field_d = field_q + 3'd1;
					end else begin
						reject_d = 1'b1;
					end
				end
				ipv4cp_pkg::TK_SLASH: begin
					if (field_q == ipv4cp_pkg::FIELD_LAST_OCTET) begin
						if (octet_q > ipv4cp_pkg::OCTET_MAX) begin
							reject_d = 1'b1;
						end
						addr_d  = {addr_q[23:0], octet_q[7:0]};
						octet_d = '0;
						field_d = ipv4cp_pkg::FIELD_PREFIX;
					end else begin
						reject_d = 1'b1;
					end
				end
				default: begin
					reject_d = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		fin_rej    = reject_d;
		fin_addr   = addr_d;
		fin_prefix = ipv4cp_pkg::PREFIX_MAX;
		if (!reject_d) begin
			if (field_d == ipv4cp_pkg::FIELD_LAST_OCTET) begin
				if (octet_d > ipv4cp_pkg::OCTET_MAX) begin
					fin_rej = 1'b1;
				end
				fin_addr = {addr_d[23:0], octet_d[7:0]};
			end else if (field_d == ipv4cp_pkg::FIELD_PREFIX) begin
				if (prefix_d > ipv4cp_pkg::PREFIX_MAX) begin
					fin_rej = 1'b1;
				end else begin
					fin_prefix = prefix_d;
				end
			end else begin
				fin_rej = 1'b1;
			end
		end
		if (fin_prefix == '0) begin
			fin_mask = '0;
		end else begin
			fin_mask = ipv4cp_pkg::MASK_ALL << (ipv4cp_pkg::PREFIX_MAX - fin_prefix);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q   <= '0;
			octet_q   <= '0;
			addr_q    <= '0;
			prefix_q  <= '0;
			reject_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				if (tok.last) begin
					field_q  <= '0;
					octet_q  <= '0;
					addr_q   <= '0;
					prefix_q <= '0;
					reject_q <= 1'b0;
				end else begin
					field_q  <= field_d;
					octet_q  <= octet_d;
					addr_q   <= addr_d;
					prefix_q <= prefix_d;
					reject_q <= reject_d;
				end
			end
			if (pop && tok.last) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && tok.last) begin
			accepted        <= !fin_rej;
			network_address <= fin_rej ? '0 : (fin_addr & fin_mask);
			net_mask        <= fin_rej ? '0 : fin_mask;
			prefix_length   <= fin_rej ? '0 : fin_prefix;
		end
	end

endmodule
